/* hdl/sbs_pkg.sv */
// shared types and constants for the saturating shade bob stamp
package sbs_pkg;

  localparam int unsigned DEF_MAX_WIDTH    = 256;
  localparam int unsigned DEF_MAX_HEIGHT   = 256;
  localparam int unsigned DEF_MAX_DIAMETER = 64;

  localparam int unsigned COORD_W  = 9;
  localparam int unsigned DIAM_W   = 7;
  localparam int unsigned RAD_W    = 6;
  localparam int unsigned PIX_W    = 8;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 9;
  localparam int unsigned DELTA_W  = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BOB_DIAMETER = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COLOR_COUNT  = 2'd3;

  localparam logic [CFG_DATA_W-1:0] RST_FRAME_WIDTH  = 9'd256;
  localparam logic [CFG_DATA_W-1:0] RST_FRAME_HEIGHT = 9'd256;
  localparam logic [DIAM_W-1:0]     RST_BOB_DIAMETER = 7'd10;
  localparam logic [PIX_W-1:0]      RST_COLOR_COUNT  = 8'd64;

  typedef enum logic [1:0] {
    KIND_CLEAR = 2'd0,
    KIND_STAMP = 2'd1,
    KIND_READ  = 2'd2,
    KIND_NONE  = 2'd3
  } sbs_kind_e;

  typedef struct packed {
    logic latch;
    logic clr_en;
    logic stamp_en;
    logic rd_en;
    logic load_res;
  } sbs_cmd_t;

  typedef struct packed {
    sbs_kind_e kind;
    logic      bad;
    logic      empty;
    logic      clr_last;
    logic      stamp_last;
    logic      pipe_busy;
    logic      out_free;
  } sbs_sts_t;

endpackage

/* hdl/shade_bob_saturating_stamp.sv */
// top level of the saturating shade bob stamp on a palette index frame
// usage:
//   s_axis carries one command per beat: tuser is the kind (clear, stamp,
//   read), tdata holds pos_x, pos_y and the dark flag. m_axis returns exactly
//   one beat per command: tdata is the pixel index (read only, else zero),
//   tuser flags a position outside the frame (command then ignored).
//   cfg_* writes frame_width, frame_height, bob_diameter and color_count by
//   index 0..3; write them only while no command is in flight.
// operation:
//   read  : one frame memory read, then the pixel goes to the output register
//   stamp : visits D*D pixels for diameter D; the frame memory port
//           handles one read-modify-write pixel per cycle through a three
//           stage pipe with forwarding
//   clear : all MAX_WIDTH*MAX_HEIGHT words, one memory word per cycle
//   one command is worked on at a time; the next is accepted once the
//   current result sits in the output register
// reset: config registers take their defaults, the frame content stays
//   undefined until the first clear; software clears before anything else
// stall: a result held by m_axis_tready low stays in the output register;
//   a new command may be taken and worked on, its result waits its turn
module shade_bob_saturating_stamp #(
  parameter int unsigned MAX_WIDTH    = sbs_pkg::DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT   = sbs_pkg::DEF_MAX_HEIGHT,
  parameter int unsigned MAX_DIAMETER = sbs_pkg::DEF_MAX_DIAMETER
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // command stream
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [23:0]                    s_axis_tdata,  // pos_x[7:0], pos_y[15:8], dark[16]
  input  logic [1:0]                     s_axis_tuser,  // kind[1:0]
  // result stream
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [7:0]                     m_axis_tdata,  // pixel_value[7:0]
  output logic                           m_axis_tuser,  // bad_position[0]
  // register write channel
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [sbs_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [sbs_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import sbs_pkg::*;

  sbs_cmd_t cmd;
  sbs_sts_t sts;

  // registers are always writable
  assign cfg_ready_o = 1'b1;

  sbs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  sbs_datapath #(
    .MAX_WIDTH    (MAX_WIDTH),
    .MAX_HEIGHT   (MAX_HEIGHT),
    .MAX_DIAMETER (MAX_DIAMETER)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_kind_i   (s_axis_tuser),
    .in_pos_x_i  (s_axis_tdata[7:0]),
    .in_pos_y_i  (s_axis_tdata[15:8]),
    .in_dark_i   (s_axis_tdata[16]),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_value_o (m_axis_tdata),
    .out_bad_o   (m_axis_tuser)
  );

endmodule

/* hdl/sbs_ctrl.sv */
// command sequencer for the shade bob stamp
module sbs_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  sbs_pkg::sbs_sts_t sts_i,
  output sbs_pkg::sbs_cmd_t cmd_o
);
  import sbs_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_DECODE = 7'b0000010,
    S_CLEAR  = 7'b0000100,
    S_STAMP  = 7'b0001000,
    S_DRAIN  = 7'b0010000,
    S_READ   = 7'b0100000,
    S_RESP   = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = (state_q == S_IDLE);
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts_i.kind == KIND_CLEAR) begin
          state_d = S_CLEAR;
        end else if (sts_i.kind == KIND_STAMP && !sts_i.bad && !sts_i.empty) begin
          state_d = S_STAMP;
        end else if (sts_i.kind == KIND_READ && !sts_i.bad) begin
          state_d = S_READ;
        end else begin
          state_d = S_RESP;
        end
      end
      S_CLEAR: begin
        cmd_o.clr_en = 1'b1;
        if (sts_i.clr_last) state_d = S_RESP;
      end
      S_STAMP: begin
        cmd_o.stamp_en = 1'b1;
        if (sts_i.stamp_last) state_d = S_DRAIN;
      end
      S_DRAIN: begin
        if (!sts_i.pipe_busy) state_d = S_RESP;
      end
      S_READ: begin
        cmd_o.rd_en = 1'b1;
        state_d     = S_RESP;
      end
      S_RESP: begin
        if (sts_i.out_free) begin
          cmd_o.load_res = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else         state_q <= state_d;
  end

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_res |-> sts_i.out_free)
    else $error("result loaded while output beat still pending");

  a_stamp_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_STAMP) |-> (sts_i.kind == KIND_STAMP && !sts_i.bad))
    else $error("stamping without a valid stamp command");

  a_read_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_READ) |-> !sts_i.pipe_busy)
    else $error("pixel read issued while stamp pipe still busy");

endmodule

/* hdl/sbs_datapath.sv */
// frame memory, stamp pipeline, config registers and result register
module sbs_datapath #(
  parameter int unsigned MAX_WIDTH    = sbs_pkg::DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT   = sbs_pkg::DEF_MAX_HEIGHT,
  parameter int unsigned MAX_DIAMETER = sbs_pkg::DEF_MAX_DIAMETER
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  input  logic [sbs_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [sbs_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic [1:0]                       in_kind_i,
  input  logic [7:0]                       in_pos_x_i,
  input  logic [7:0]                       in_pos_y_i,
  input  logic                             in_dark_i,
  input  sbs_pkg::sbs_cmd_t                cmd_i,
  output sbs_pkg::sbs_sts_t                sts_o,
  input  logic                             out_ready_i,
  output logic                             out_valid_o,
  output logic [sbs_pkg::PIX_W-1:0]        out_value_o,
  output logic                             out_bad_o
);
  import sbs_pkg::*;

  localparam int unsigned DEPTH  = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned ADDR_W = $clog2(DEPTH);

  // config registers
  logic [COORD_W-1:0] frame_width_q, frame_height_q;
  logic [DIAM_W-1:0]  bob_diameter_q;
  logic [PIX_W-1:0]   color_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= RST_FRAME_WIDTH;
      frame_height_q <= RST_FRAME_HEIGHT;
      bob_diameter_q <= RST_BOB_DIAMETER;
      color_count_q  <= RST_COLOR_COUNT;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_FRAME_WIDTH:  frame_width_q  <= cfg_data_i;
        CFG_FRAME_HEIGHT: frame_height_q <= cfg_data_i;
        CFG_BOB_DIAMETER: bob_diameter_q <= cfg_data_i[DIAM_W-1:0];
        CFG_COLOR_COUNT:  color_count_q  <= cfg_data_i[PIX_W-1:0];
        default: ;
      endcase
    end
  end

  // limited geometry
  logic [COORD_W-1:0] fw, fh;
  logic [DIAM_W-1:0]  diam;
  logic [RAD_W-1:0]   rad;
  logic [PIX_W-1:0]   top;

  assign fw   = (int'(frame_width_q) > MAX_WIDTH) ? COORD_W'(MAX_WIDTH) : frame_width_q;
  assign fh   = (int'(frame_height_q) > MAX_HEIGHT) ? COORD_W'(MAX_HEIGHT) : frame_height_q;
  assign diam = (int'(bob_diameter_q) > MAX_DIAMETER) ? DIAM_W'(MAX_DIAMETER)
                                                       : bob_diameter_q;
  assign rad  = diam[DIAM_W-1:1];
  assign top  = (color_count_q == '0) ? '0 : color_count_q - 8'd1;

  // command latch
  sbs_kind_e          kind_q;
  logic [COORD_W-1:0] px_q, py_q;
  logic               dark_q;
  logic [11:0]        rr_q;

  // scan counters
  logic [ADDR_W-1:0]  clr_q;
  logic [DIAM_W-1:0]  a_q, b_q;
  logic [COORD_W-1:0] x_q, y_q;
  logic [ADDR_W-1:0]  ybase_q;

  logic [11:0] rr_full;
  assign rr_full = 12'(rad) * 12'(rad);

  logic a_end, x_wrap, y_wrap;
  assign a_end  = (a_q == diam - 7'd1);
  assign x_wrap = (x_q + 9'd1 == fw);
  assign y_wrap = (y_q + 9'd1 == fh);

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      kind_q  <= sbs_kind_e'(in_kind_i);
      px_q    <= COORD_W'(in_pos_x_i);
      py_q    <= COORD_W'(in_pos_y_i);
      dark_q  <= in_dark_i;
      rr_q    <= rr_full;
      clr_q   <= '0;
      a_q     <= '0;
      b_q     <= '0;
      x_q     <= COORD_W'(in_pos_x_i);
      y_q     <= COORD_W'(in_pos_y_i);
      ybase_q <= ADDR_W'(in_pos_y_i) * ADDR_W'(MAX_WIDTH);
    end else begin
      if (cmd_i.clr_en) clr_q <= clr_q + 1'b1;
      if (cmd_i.stamp_en) begin
        if (a_end) begin
          a_q     <= '0;
          x_q     <= px_q;
          b_q     <= b_q + 7'd1;
          y_q     <= y_wrap ? '0 : y_q + 9'd1;
          ybase_q <= y_wrap ? '0 : ybase_q + ADDR_W'(MAX_WIDTH);
        end else begin
          a_q <= a_q + 7'd1;
          x_q <= x_wrap ? '0 : x_q + 9'd1;
        end
      end
    end
  end

  // stage 0: offsets squared
  logic signed [8:0]  tw, th;
  logic signed [17:0] sqw_full, sqh_full;
  assign tw = $signed({1'b0, a_q, 1'b1}) - $signed({2'b00, rad, 1'b0});
  assign th = $signed({1'b0, b_q, 1'b1}) - $signed({2'b00, rad, 1'b0});
  assign sqw_full = tw * tw;
  assign sqh_full = th * th;

  logic              p1_vld_q, p2_vld_q;
  logic [ADDR_W-1:0] p1_addr_q, p2_addr_q;
  logic [15:0]       p1_sqw_q, p1_sqh_q;
  logic              p1_zero_q;
  logic [DELTA_W-1:0] p2_delta_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_vld_q <= 1'b0;
      p2_vld_q <= 1'b0;
    end else begin
      p1_vld_q <= cmd_i.stamp_en;
      p2_vld_q <= p1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    p1_addr_q <= ybase_q + ADDR_W'(x_q);
    p1_sqw_q  <= sqw_full[15:0];
    p1_sqh_q  <= sqh_full[15:0];
    p1_zero_q <= ({1'b0, a_q} >= {1'b0, rad, 1'b0}) || ({1'b0, b_q} >= {1'b0, rad, 1'b0});
  end

  // stage 1: shape level, largest k whose ring holds the offset
  function automatic logic [DELTA_W-1:0] shape_level(input logic [20:0] lhs,
                                                     input logic [11:0] rr);
    logic [DELTA_W-1:0] k;
    k = '0;
    for (int f = 8; f >= 1; f--) begin
      if (lhs <= 21'(rr) * 21'(f * f)) k = DELTA_W'(9 - f);
    end
    return k;
  endfunction

  logic [16:0] s_sum;
  assign s_sum = 17'(p1_sqw_q) + 17'(p1_sqh_q);

  always_ff @(posedge clk_i) begin
    p2_addr_q  <= p1_addr_q;
    p2_delta_q <= p1_zero_q ? '0 : shape_level({s_sum, 4'b0000}, rr_q);
  end

  // stage 2: saturating update with forwarding of the write in flight
  logic [PIX_W-1:0] rd_q, fwd_data_q, old_pix, new_pix;
  logic             fwd_q;
  logic signed [9:0] sum_v, dlt;

  assign old_pix = fwd_q ? fwd_data_q : rd_q;
  assign dlt     = dark_q ? -$signed({6'b0, p2_delta_q}) : $signed({6'b0, p2_delta_q});
  assign sum_v   = $signed({2'b00, old_pix}) + dlt;

  always_comb begin
    if (sum_v > $signed({2'b00, top})) new_pix = top;
    else if (sum_v < 0)                new_pix = '0;
    else                               new_pix = sum_v[PIX_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) fwd_q <= 1'b0;
    else         fwd_q <= p1_vld_q && p2_vld_q && (p1_addr_q == p2_addr_q);
  end

  always_ff @(posedge clk_i) begin
    fwd_data_q <= new_pix;
  end

  // frame memory, one write and one read port
  logic [PIX_W-1:0]  mem_q [DEPTH];
  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;
  logic [PIX_W-1:0]  mem_wdata;

  assign mem_we    = cmd_i.clr_en || p2_vld_q;
  assign mem_waddr = cmd_i.clr_en ? clr_q : p2_addr_q;
  assign mem_wdata = cmd_i.clr_en ? '0 : new_pix;
  assign mem_re    = cmd_i.rd_en || p1_vld_q;
  assign mem_raddr = cmd_i.rd_en ? (ybase_q + ADDR_W'(px_q)) : p1_addr_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_waddr] <= mem_wdata;
    if (mem_re) rd_q <= mem_q[mem_raddr];
  end

  // status
  logic bad;
  assign bad = (px_q >= fw) || (py_q >= fh);

  logic out_valid_q;
  logic [PIX_W-1:0] out_value_q;
  logic out_bad_q;

  always_comb begin
    sts_o.kind       = kind_q;
    sts_o.bad        = bad;
    sts_o.empty      = (diam == '0);
    sts_o.clr_last   = (clr_q == ADDR_W'(DEPTH - 1));
    sts_o.stamp_last = a_end && (b_q == diam - 7'd1);
    sts_o.pipe_busy  = p1_vld_q || p2_vld_q;
    sts_o.out_free   = !out_valid_q || out_ready_i;
  end

  // result register
  logic is_pos_cmd;
  assign is_pos_cmd = (kind_q == KIND_STAMP) || (kind_q == KIND_READ);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (cmd_i.load_res) out_valid_q <= 1'b1;
    else if (out_ready_i) out_valid_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_res) begin
      out_value_q <= (kind_q == KIND_READ && !bad) ? rd_q : '0;
      out_bad_q   <= is_pos_cmd && bad;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_value_o = out_value_q;
  assign out_bad_o   = out_bad_q;

  a_port_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.clr_en && p2_vld_q))
    else $error("clear sweep collides with stamp write");

  a_port_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.rd_en && p1_vld_q))
    else $error("pixel read collides with stamp read");

  a_pipe_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    p2_vld_q |-> $past(p1_vld_q))
    else $error("stamp stage 2 valid without stage 1");

  a_fwd_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fwd_q |-> p2_vld_q)
    else $error("forwarded pixel with no update in stage 2");

endmodule
